/* sv/pmce_pkg.sv */
// Shared types, constants and helper functions of the pad mux configuration engine.
`timescale 1ns / 1ps
`default_nettype none
package pmce_pkg;

  localparam int PAD_COUNT = 128;
  localparam int SLOT_W    = $clog2(PAD_COUNT);
  localparam int PIN_W     = 16;
  localparam int FN_W      = 3;
  localparam int OFFSET_W  = 10;
  localparam int WORD_W    = 32;
  localparam int CTRL_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  // Pad control word fields, lower half only
  localparam logic [CTRL_W-1:0] MUX_BITS    = 16'h0007;
  localparam logic [CTRL_W-1:0] STRONG_BIT  = 16'h0008;
  localparam logic [CTRL_W-1:0] EDGE_RISE   = 16'h0010;
  localparam logic [CTRL_W-1:0] EDGE_FALL   = 16'h0020;
  localparam logic [CTRL_W-1:0] EDGE_NO_DETECT = 16'h0040;
  localparam logic [CTRL_W-1:0] DRIVE_BITS  = 16'h1C00;
  localparam int                DRIVE_POS   = 10;
  localparam logic [CTRL_W-1:0] PULL_DOWN   = 16'h2000;
  localparam logic [CTRL_W-1:0] PULL_UP     = 16'h4000;
  localparam logic [CTRL_W-1:0] PULL_ENABLE = 16'h8000;
  localparam logic [CTRL_W-1:0] PULL_BITS   = PULL_ENABLE | PULL_UP | PULL_DOWN;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PINCONF_ENABLE  = 3'd0,
    CFG_BIAS_MODE       = 3'd1,
    CFG_STRONG_PULL     = 3'd2,
    CFG_DRIVE_PRESENT   = 3'd3,
    CFG_DRIVE_MA        = 3'd4,
    CFG_LOW_VOLTAGE_PAD = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BIAS_NONE    = 2'd0,
    BIAS_PULL_UP = 2'd1,
    BIAS_PULL_DN = 2'd2,
    BIAS_DISABLE = 2'd3
  } bias_t;

  // One classified mux entry, as queued between front and back
  typedef struct packed {
    logic                skipped;
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] offset;
    logic [FN_W-1:0]     fn;
    logic [CTRL_W-1:0]   msk;
    logic [CTRL_W-1:0]   val;
  } item_t;

  // Piecewise pin to byte offset map
  function automatic logic [OFFSET_W-1:0] pin_offset(input logic [SLOT_W-1:0] p);
    logic [7:0] pe;
    logic [7:0] w;
    pe = {1'b0, p};
    if (pe <= 8'd85)       w = pe + 8'd1;
    else if (pe <= 8'd92)  w = pe + 8'd37;
    else if (pe <= 8'd97)  w = pe + 8'd24;
    else if (pe == 8'd98)  w = 8'd93;
    else if (pe == 8'd99)  w = 8'd92;
    else if (pe == 8'd100) w = 8'd91;
    else if (pe == 8'd101) w = 8'd90;
    else if (pe == 8'd102) w = 8'd95;
    else if (pe == 8'd103) w = 8'd94;
    else if (pe <= 8'd110) w = pe + 8'd6;
    else                   w = pe + 8'd20;
    return {w, 2'b00};
  endfunction

  // First drive table entry at or above the request; last entry above the top
  function automatic logic [2:0] pick_drive(input logic lv, input logic [7:0] ma);
    logic [2:0] code;
    if (lv) begin
      if (ma <= 8'd11)      code = 3'd0;
      else if (ma <= 8'd21) code = 3'd2;
      else if (ma <= 8'd32) code = 3'd4;
      else                  code = 3'd6;
    end else begin
      if (ma <= 8'd7)       code = 3'd0;
      else if (ma <= 8'd10) code = 3'd2;
      else if (ma <= 8'd13) code = 3'd4;
      else if (ma <= 8'd16) code = 3'd6;
      else if (ma <= 8'd19) code = 3'd1;
      else if (ma <= 8'd23) code = 3'd3;
      else if (ma <= 8'd26) code = 3'd5;
      else                  code = 3'd7;
    end
    return code;
  endfunction

endpackage
`default_nettype wire

/* sv/pmce_front.sv */
// Front end: configuration registers, entry acceptance and classification.
`timescale 1ns / 1ps
`default_nettype none
module pmce_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pmce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pmce_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pmce_pkg::PIN_W-1:0]        pin,
  input  wire logic [pmce_pkg::FN_W-1:0]         function_req,
  output logic                                   push,
  output pmce_pkg::item_t                        push_item,
  input  wire logic                              q_full
);

  logic       pinconf_enable;
  logic [1:0] bias_mode;
  logic       strong_pull;
  logic       drive_present;
  logic [7:0] drive_ma;
  logic       low_voltage_pad;

  logic            f_vld;
  pmce_pkg::item_t f_item;
  pmce_pkg::item_t cls;
  logic [pmce_pkg::CTRL_W-1:0] msk;
  logic [pmce_pkg::CTRL_W-1:0] val;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      pinconf_enable  <= 1'b0;
      bias_mode       <= 2'd0;
      strong_pull     <= 1'b1;
      drive_present   <= 1'b0;
      drive_ma        <= 8'd0;
      low_voltage_pad <= 1'b0;
    end else if (cfg_we) begin
      unique case (pmce_pkg::cfg_idx_t'(cfg_index))
        pmce_pkg::CFG_PINCONF_ENABLE:  pinconf_enable  <= cfg_data[0];
        pmce_pkg::CFG_BIAS_MODE:       bias_mode       <= cfg_data[1:0];
        pmce_pkg::CFG_STRONG_PULL:     strong_pull     <= cfg_data[0];
        pmce_pkg::CFG_DRIVE_PRESENT:   drive_present   <= cfg_data[0];
        pmce_pkg::CFG_DRIVE_MA:        drive_ma        <= cfg_data;
        pmce_pkg::CFG_LOW_VOLTAGE_PAD: low_voltage_pad <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Build mask and value of the settings merge
  always_comb begin
    msk = '0;
    val = '0;
    if (pinconf_enable) begin
      unique case (pmce_pkg::bias_t'(bias_mode))
        pmce_pkg::BIAS_PULL_UP: begin
          msk = pmce_pkg::PULL_BITS | pmce_pkg::STRONG_BIT;
          val = pmce_pkg::PULL_ENABLE | pmce_pkg::PULL_UP
              | (strong_pull ? pmce_pkg::STRONG_BIT : '0);
        end
        pmce_pkg::BIAS_PULL_DN: begin
          msk = pmce_pkg::PULL_BITS | pmce_pkg::STRONG_BIT;
          val = pmce_pkg::PULL_ENABLE | pmce_pkg::PULL_DOWN;
        end
        pmce_pkg::BIAS_DISABLE: begin
          msk = pmce_pkg::PULL_BITS | pmce_pkg::STRONG_BIT;
        end
        default: ;
      endcase
      if (drive_present) begin
        msk = msk | pmce_pkg::DRIVE_BITS;
        val = val | (pmce_pkg::CTRL_W'(pmce_pkg::pick_drive(low_voltage_pad, drive_ma))
                     << pmce_pkg::DRIVE_POS);
      end
      if (msk != '0) begin
        msk = msk | pmce_pkg::EDGE_NO_DETECT | pmce_pkg::EDGE_RISE | pmce_pkg::EDGE_FALL;
        val = val | pmce_pkg::EDGE_NO_DETECT;
      end
    end
  end

  always_comb begin
    cls.skipped = |pin[pmce_pkg::PIN_W-1:pmce_pkg::SLOT_W];
    cls.slot    = pin[pmce_pkg::SLOT_W-1:0];
    cls.offset  = cls.skipped ? '0 : pmce_pkg::pin_offset(pin[pmce_pkg::SLOT_W-1:0]);
    cls.fn      = function_req;
    cls.msk     = msk;
    cls.val     = val;
  end

  assign push      = f_vld && !q_full;
  assign push_item = f_item;
  assign in_stall  = f_vld && q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (accept) begin
      f_vld <= 1'b1;
    end else if (push) begin
      f_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= cls;
    end
  end

endmodule
`default_nettype wire

/* sv/pmce_fifo.sv */
// Short queue of classified entries between front and back.
`timescale 1ns / 1ps
`default_nettype none
module pmce_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire pmce_pkg::item_t push_item,
  output logic                 full,
  output logic                 q_valid,
  output pmce_pkg::item_t      q_item,
  input  wire logic            pop
);

  pmce_pkg::item_t             slots [pmce_pkg::Q_DEPTH];
  logic [pmce_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [pmce_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [pmce_pkg::Q_PTR_W:0]   count;

  assign full    = (count == (pmce_pkg::Q_PTR_W + 1)'(pmce_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)          count <= count + 1'b1;
      else if (pop && !push)     count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* sv/pmce_back.sv */
// Back end: pad store read-modify-write and result register.
`timescale 1ns / 1ps
`default_nettype none
module pmce_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire pmce_pkg::item_t                   q_item,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   skipped,
  output logic [pmce_pkg::OFFSET_W-1:0]          reg_offset,
  output logic [pmce_pkg::WORD_W-1:0]            old_word,
  output logic [pmce_pkg::WORD_W-1:0]            new_word,
  output logic                                   wrote
);

  typedef enum logic {S_IDLE, S_RMW} state_t;

  state_t                      state;
  pmce_pkg::item_t             cur;
  logic [pmce_pkg::WORD_W-1:0] mem [pmce_pkg::PAD_COUNT];
  logic [pmce_pkg::WORD_W-1:0] rdata;
  logic                        rd_vld;
  logic [pmce_pkg::PAD_COUNT-1:0] written;
  logic [pmce_pkg::WORD_W-1:0] prev;
  logic [pmce_pkg::WORD_W-1:0] next;
  logic [pmce_pkg::CTRL_W-1:0] low;
  logic                        changed;
  logic                        wr_en;

  assign pop = (state == S_IDLE) && q_valid && (!out_valid || !out_stall);

  // Never-written entries read as zero
  assign prev = rd_vld ? rdata : '0;

  always_comb begin
    low = (prev[pmce_pkg::CTRL_W-1:0] & ~pmce_pkg::MUX_BITS)
        | pmce_pkg::CTRL_W'(cur.fn);
    low = (low & ~cur.msk) | (cur.val & cur.msk);
    next = {prev[pmce_pkg::WORD_W-1:pmce_pkg::CTRL_W], low};
  end

  assign changed = (next != prev);
  assign wr_en   = (state == S_RMW) && !cur.skipped && changed;

  always_ff @(posedge clk) begin
    if (wr_en) mem[cur.slot] <= next;
    if (pop) begin
      rdata <= mem[q_item.slot];
      cur   <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) written[cur.slot] <= 1'b1;
      if (pop)   rd_vld <= written[q_item.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) state <= S_RMW;
        end
        S_RMW: begin
          state      <= S_IDLE;
          out_valid  <= 1'b1;
          skipped    <= cur.skipped;
          reg_offset <= cur.offset;
          old_word   <= cur.skipped ? '0 : prev;
          new_word   <= cur.skipped ? '0 : next;
          wrote      <= !cur.skipped && changed;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/pad_mux_config_engine_top.sv */
// Top level of the pad mux configuration engine.
// Usage:
//   Input channel (in_valid / in_stall, pin, function_req) carries one pin-mux
//   entry per transfer. Output channel (out_valid / out_stall) returns one result
//   per entry: skipped, reg_offset, old_word, new_word and wrote.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user must
//   do so only while the block is idle (not enforced); other indices are dropped.
// Path: an accepted entry is registered in the front end, then written to the
//   queue, read from the pad store, and merged into the result register.
// Back end pacing: the back end reads the pad store through a registered read
//   port and writes the merged word in the following cycle, and the next read
//   is issued only after that write, so entries do not overlap in the back end.
// Reset: rst (synchronous) empties the pipeline and returns the registers to
//   their defaults (strong_pull set, all others clear). The pad store needs no
//   clearing pass: a per-pad written flag makes every pad read as zero until
//   first stored, so entries are taken from the first cycle after reset.
// Stall: a stalled result holds in the output register; the queue then fills
//   and in_stall rises to back-pressure the sender.
`timescale 1ns / 1ps
`default_nettype none
module pad_mux_config_engine_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [pmce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pmce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [pmce_pkg::PIN_W-1:0]      pin,
  input  wire logic [pmce_pkg::FN_W-1:0]       function_req,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 skipped,
  output logic [pmce_pkg::OFFSET_W-1:0]        reg_offset,
  output logic [pmce_pkg::WORD_W-1:0]          old_word,
  output logic [pmce_pkg::WORD_W-1:0]          new_word,
  output logic                                 wrote
);

  // Front to queue transfer
  logic            push;
  pmce_pkg::item_t push_item;
  logic            q_full;
  // Queue to back transfer
  logic            q_valid;
  pmce_pkg::item_t q_item;
  logic            pop;

  // Accept and classify entries, hold configuration
  pmce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pin          (pin),
    .function_req (function_req),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Decouple front and back so each may stall on its own
  pmce_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Read-modify-write the pad store and present the result
  pmce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .skipped    (skipped),
    .reg_offset (reg_offset),
    .old_word   (old_word),
    .new_word   (new_word),
    .wrote      (wrote)
  );

endmodule
`default_nettype wire

/* sv/pmce_checker.sv */
// Port-level checker of the pad mux configuration engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pmce_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [pmce_pkg::PIN_W-1:0]      pin,
  input wire logic [pmce_pkg::FN_W-1:0]       function_req,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            skipped,
  input wire logic [pmce_pkg::OFFSET_W-1:0]   reg_offset,
  input wire logic [pmce_pkg::WORD_W-1:0]     old_word,
  input wire logic [pmce_pkg::WORD_W-1:0]     new_word,
  input wire logic                            wrote
);

  // Hold a stalled entry
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(pin) && $stable(function_req))
    else $error("stalled entry changed");

  // Hold a stalled result valid with its old and new words
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_word) && $stable(old_word))
    else $error("stalled result changed");

  // Drop everything on a skipped pin
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && skipped |-> !wrote && reg_offset == '0 && old_word == '0 && new_word == '0)
    else $error("skipped result carries data");

  // Store only a changed word; offsets are word aligned
  a_wrote: assert property (@(posedge clk) disable iff (rst)
    out_valid && !skipped |-> wrote == (new_word != old_word) && reg_offset[1:0] == 2'b00)
    else $error("wrote flag or offset alignment wrong");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pad_mux_config_engine_top pmce_checker u_pmce_checker (.*);
`default_nettype wire
